[design/mwm_pkg.sv]
// Shared constants, types and tables for the mecanum wheel mixer.
`default_nettype none

package mwm_pkg;

   localparam int WHEELS = 4;
   localparam int IN_W = 16;

   // CORDIC datapath
   localparam int CW = 27;
   localparam int ZW = 18;
   localparam int PRESCALE = 8;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_PER_STAGE = 2;
   localparam int QUARTER_TURN = 16384;
   localparam int HALF_TURN = 32768;
   localparam int GAIN_INV = 39797;
   localparam int GAIN_W = 17;
   localparam int GAIN_SHIFT = 24;
   localparam int PCW = CW + GAIN_W;

   // speed datapath
   localparam int RW = 18;
   localparam int SW = 18;
   localparam int MW = 17;
   localparam int FRAC = 15;
   localparam int ONE_Q15 = 32768;
   localparam int QW = 15;
   localparam int MAGW = 16;
   localparam int DIV_STEPS = 15;
   localparam int DIV_PER_STAGE = 3;
   localparam int DIV_LANES = 2 * WHEELS;

   // control registers
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 15;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PEG_THRESHOLD = 2'd2;
   localparam logic [14:0] MAX_SPEED_RESET = 15'd1000;
   localparam logic [3:0] INVERT_MASK_RESET = 4'd0;
   localparam logic [14:0] PEG_THRESHOLD_RESET = 15'd32440;

   typedef struct packed {
      logic [IN_W-1:0] r;
      logic [WHEELS-1:0][IN_W-1:0] drive;
      logic [WHEELS-1:0][IN_W-1:0] rate;
   } side_type;

   typedef struct packed {
      logic [WHEELS-1:0] sgn;
      logic [WHEELS-1:0][MW-1:0] mag;
      logic [MW-1:0] peak;
      logic do_norm;
      logic [WHEELS-1:0] lim_ok;
      logic [WHEELS-1:0][QW-1:0] rmag;
   } peak_type;

   typedef struct packed {
      peak_type pk;
      logic [WHEELS-1:0][QW-1:0] q_s;
      logic [WHEELS-1:0][QW-1:0] q_r;
   } quot_type;

   // arctangent of 2^-i in binary-angle units
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0: v = ZW'(8192);
         1: v = ZW'(4836);
         2: v = ZW'(2555);
         3: v = ZW'(1297);
         4: v = ZW'(651);
         5: v = ZW'(326);
         6: v = ZW'(163);
         7: v = ZW'(81);
         8: v = ZW'(41);
         9: v = ZW'(20);
         10: v = ZW'(10);
         11: v = ZW'(5);
         12: v = ZW'(3);
         13: v = ZW'(1);
         14: v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // magnitude of a 16-bit two's complement value (-32768 gives 32768)
   function automatic logic [IN_W-1:0] mag16(input logic [IN_W-1:0] v);
      logic [IN_W-1:0] m;
      m = v[IN_W-1] ? (~v + 16'd1) : v;
      return m;
   endfunction

endpackage

`default_nettype wire

[design/mecanum_wheel_mixer_equalizer.sv]
// Top level of the mecanum wheel mixer with pegged-wheel equalization.
//
// Usage:
//  - req_*: one drive command per transfer (x, y, rotate, heading, and per
//    wheel the present drive level and measured rate). Accepted when
//    req_valid is high and req_stall is low.
//  - rsp_*: four wheel rate setpoints per transfer, taken when rsp_valid
//    is high and rsp_stall is low. One result for every command, in order.
//  - csr_*: register writes (0 max_speed, 1 invert_mask, 2 peg_threshold),
//    taken on csr_valid; csr_ready is always high. Index 3 is ignored.
//    Write only while no command is in flight.
//  - Pipeline from transfer in to rsp_valid: CORDIC, mix, peak, dividers,
//    limit/scale. Throughput: one command per cycle while rsp_stall is low;
//    the 16-step CORDIC and 15-step dividers are fully pipelined.
//  - Reset: registers return to 1000 / 0 / 32440 and the pipeline empties.
//  - Stall: a held result keeps its register; earlier stages keep filling
//    bubbles, and req_stall rises only once every stage holds a command.
`default_nettype none

module mecanum_wheel_mixer_equalizer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [15:0]                    req_cmd_x,
   input  wire logic signed [15:0]                    req_cmd_y,
   input  wire logic signed [15:0]                    req_cmd_rotate,
   input  wire logic [15:0]                           req_heading,
   input  wire logic signed [15:0]                    req_drive_fl,
   input  wire logic signed [15:0]                    req_drive_fr,
   input  wire logic signed [15:0]                    req_drive_rl,
   input  wire logic signed [15:0]                    req_drive_rr,
   input  wire logic signed [15:0]                    req_rate_fl,
   input  wire logic signed [15:0]                    req_rate_fr,
   input  wire logic signed [15:0]                    req_rate_rl,
   input  wire logic signed [15:0]                    req_rate_rr,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [15:0]                         rsp_setpoint_fl,
   output logic signed [15:0]                         rsp_setpoint_fr,
   output logic signed [15:0]                         rsp_setpoint_rl,
   output logic signed [15:0]                         rsp_setpoint_rr,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mwm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [mwm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int WH = mwm_pkg::WHEELS;
   localparam int SW = mwm_pkg::SW;
   localparam int MW = mwm_pkg::MW;
   localparam int RW = mwm_pkg::RW;

   // control registers
   logic [14:0] max_speed_ff;
   logic [3:0] invert_mask_ff;
   logic [14:0] peg_threshold_ff;
   logic [14:0] ms;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= mwm_pkg::MAX_SPEED_RESET;
         invert_mask_ff <= mwm_pkg::INVERT_MASK_RESET;
         peg_threshold_ff <= mwm_pkg::PEG_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mwm_pkg::REG_MAX_SPEED: max_speed_ff <= csr_wdata[14:0];
            mwm_pkg::REG_INVERT_MASK: invert_mask_ff <= csr_wdata[3:0];
            mwm_pkg::REG_PEG_THRESHOLD: peg_threshold_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // zero full scale behaves as one
   assign ms = (max_speed_ff == '0) ? 15'd1 : max_speed_ff;

   // CORDIC front end
   mwm_pkg::side_type side_in;
   logic cor_in_ready, cor_valid, cor_ready;
   logic signed [RW-1:0] cor_x, cor_y;
   mwm_pkg::side_type cor_side;

   assign side_in.r = req_cmd_rotate;
   assign side_in.drive[0] = req_drive_fl;
   assign side_in.drive[1] = req_drive_fr;
   assign side_in.drive[2] = req_drive_rl;
   assign side_in.drive[3] = req_drive_rr;
   assign side_in.rate[0] = req_rate_fl;
   assign side_in.rate[1] = req_rate_fr;
   assign side_in.rate[2] = req_rate_rl;
   assign side_in.rate[3] = req_rate_rr;

   assign req_stall = !cor_in_ready;

   mwm_cordic u_cordic (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (cor_in_ready),
      .in_x       (req_cmd_x),
      .in_y       (req_cmd_y),
      .in_heading (req_heading),
      .in_side    (side_in),
      .out_valid  (cor_valid),
      .out_ready  (cor_ready),
      .out_x      (cor_x),
      .out_y      (cor_y),
      .out_side   (cor_side)
   );

   // mix stage: wheel speeds, inversion, pegged flags, rate magnitudes
   logic v_mix_ff;
   logic signed [SW-1:0] s_ff [0:WH-1];
   logic [WH-1:0] pegged_ff;
   logic [15:0] rmag_ff [0:WH-1];
   logic signed [SW-1:0] s_in [0:WH-1];
   logic signed [SW-1:0] xe, ye, re;
   logic rdy_mix;

   // peak stage
   logic v_pk_ff;
   mwm_pkg::peak_type pk_ff;
   mwm_pkg::peak_type pk_in;
   logic rdy_pk;
   logic norm_in_ready;

   assign rdy_pk = !v_pk_ff || norm_in_ready;
   assign rdy_mix = !v_mix_ff || rdy_pk;
   assign cor_ready = rdy_mix;

   always_comb begin
      xe = SW'(cor_x);
      ye = SW'(cor_y);
      re = SW'($signed(cor_side.r));
      s_in[0] = xe + ye + re;
      s_in[1] = ye - xe - re;
      s_in[2] = ye - xe + re;
      s_in[3] = xe + ye - re;
      for (int l = 0; l < WH; l++) begin
         if (invert_mask_ff[l]) begin
            s_in[l] = -s_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_mix_ff <= 1'b0;
      end else if (rdy_mix) begin
         v_mix_ff <= cor_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_mix) begin
         for (int l = 0; l < WH; l++) begin
            s_ff[l] <= s_in[l];
            pegged_ff[l] <= mwm_pkg::mag16(cor_side.drive[l]) > {1'b0, peg_threshold_ff};
            rmag_ff[l] <= mwm_pkg::mag16(cor_side.rate[l]);
         end
      end
   end

   // magnitudes, largest magnitude, and which wheels may limit
   always_comb begin
      logic [MW-1:0] m01, m23;
      for (int l = 0; l < WH; l++) begin
         pk_in.sgn[l] = s_ff[l][SW-1];
         pk_in.mag[l] = s_ff[l][SW-1] ? MW'(-s_ff[l]) : MW'(s_ff[l]);
         pk_in.lim_ok[l] = pegged_ff[l] && (rmag_ff[l] < {1'b0, ms});
         pk_in.rmag[l] = rmag_ff[l][14:0];
      end
      m01 = (pk_in.mag[0] > pk_in.mag[1]) ? pk_in.mag[0] : pk_in.mag[1];
      m23 = (pk_in.mag[2] > pk_in.mag[3]) ? pk_in.mag[2] : pk_in.mag[3];
      pk_in.peak = (m01 > m23) ? m01 : m23;
      pk_in.do_norm = pk_in.peak > MW'(mwm_pkg::ONE_Q15);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_pk_ff <= 1'b0;
      end else if (rdy_pk) begin
         v_pk_ff <= v_mix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_pk) begin
         pk_ff <= pk_in;
      end
   end

   // dividers
   logic norm_valid, norm_ready;
   mwm_pkg::quot_type norm_q;

   mwm_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_pk_ff),
      .in_ready  (norm_in_ready),
      .in_pk     (pk_ff),
      .ms        (ms),
      .out_valid (norm_valid),
      .out_ready (norm_ready),
      .out_q     (norm_q)
   );

   // limit, clamp, scale, result register
   logic [WH-1:0][15:0] setpoint;

   mwm_limit u_limit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (norm_ready),
      .in_q      (norm_q),
      .ms        (ms),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .setpoint  (setpoint)
   );

   assign rsp_setpoint_fl = setpoint[0];
   assign rsp_setpoint_fr = setpoint[1];
   assign rsp_setpoint_rl = setpoint[2];
   assign rsp_setpoint_rr = setpoint[3];

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   assert property (@(posedge clock) disable iff (reset)
      v_pk_ff |-> (pk_ff.mag[0] <= pk_ff.peak) && (pk_ff.mag[1] <= pk_ff.peak)
               && (pk_ff.mag[2] <= pk_ff.peak) && (pk_ff.mag[3] <= pk_ff.peak))
      else $error("peak below a wheel magnitude");

   assert property (@(posedge clock) disable iff (reset)
      (v_pk_ff && pk_ff.do_norm) |-> (pk_ff.peak != '0))
      else $error("normalize with zero peak");

endmodule

`default_nettype wire

[design/mwm_cordic.sv]
// Pipelined CORDIC rotation of the command vector with gain correction.
`default_nettype none

module mwm_cordic (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [mwm_pkg::IN_W-1:0]      in_x,
   input  wire logic [mwm_pkg::IN_W-1:0]      in_y,
   input  wire logic [mwm_pkg::IN_W-1:0]      in_heading,
   input  wire mwm_pkg::side_type             in_side,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [mwm_pkg::RW-1:0]      out_x,
   output logic signed [mwm_pkg::RW-1:0]      out_y,
   output mwm_pkg::side_type                  out_side
);

   localparam int CW = mwm_pkg::CW;
   localparam int ZW = mwm_pkg::ZW;
   localparam int PER = mwm_pkg::CORDIC_PER_STAGE;
   localparam int NS = mwm_pkg::CORDIC_STEPS / PER;
   localparam int NST = NS + 3;
   localparam int PCW = mwm_pkg::PCW;

   logic [NST-1:0] v_ff;
   logic [NST:0] rdy;

   logic signed [CW-1:0] x_ff [0:NS];
   logic signed [CW-1:0] y_ff [0:NS];
   logic signed [ZW-1:0] z_ff [0:NS];
   mwm_pkg::side_type sb_ff [0:NST-1];
   logic signed [PCW-1:0] px_ff, py_ff;
   logic signed [mwm_pkg::RW-1:0] rx_ff, ry_ff;

   logic signed [CW-1:0] x0_in, y0_in;
   logic signed [ZW-1:0] z0_in;
   logic signed [PCW-1:0] gain;
   logic signed [PCW-1:0] xr, yr;

   // stall chain: a stage takes new data when empty or when it drains
   always_comb begin
      rdy[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready = rdy[0];
   assign out_valid = v_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // prescale and fold the angle into +-90 degrees by a half turn
   always_comb begin
      x0_in = CW'($signed(in_x)) <<< mwm_pkg::PRESCALE;
      y0_in = CW'($signed(in_y)) <<< mwm_pkg::PRESCALE;
      z0_in = ZW'($signed(in_heading));
      if (z0_in > ZW'(mwm_pkg::QUARTER_TURN)) begin
         x0_in = -x0_in;
         y0_in = -y0_in;
         z0_in = z0_in - ZW'(mwm_pkg::HALF_TURN);
      end else if (z0_in < -ZW'(mwm_pkg::QUARTER_TURN)) begin
         x0_in = -x0_in;
         y0_in = -y0_in;
         z0_in = z0_in + ZW'(mwm_pkg::HALF_TURN);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
         sb_ff[0] <= in_side;
      end
   end

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_it
         logic signed [CW-1:0] xs, ys, xn;
         logic signed [ZW-1:0] zs;

         always_comb begin
            xs = x_ff[k];
            ys = y_ff[k];
            zs = z_ff[k];
            xn = xs;
            for (int j = 0; j < PER; j++) begin
               if (!zs[ZW-1]) begin
                  xn = xs - (ys >>> (k * PER + j));
                  ys = ys + (xs >>> (k * PER + j));
                  zs = zs - mwm_pkg::atan_entry(k * PER + j);
               end else begin
                  xn = xs + (ys >>> (k * PER + j));
                  ys = ys - (xs >>> (k * PER + j));
                  zs = zs + mwm_pkg::atan_entry(k * PER + j);
               end
               xs = xn;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k+1]) begin
               x_ff[k+1] <= xs;
               y_ff[k+1] <= ys;
               z_ff[k+1] <= zs;
               sb_ff[k+1] <= sb_ff[k];
            end
         end
      end
   endgenerate

   // gain correction, then round half up to Q15
   assign gain = PCW'($signed({1'b0, 16'(mwm_pkg::GAIN_INV)}));

   always_ff @(posedge clock) begin
      if (rdy[NS+1]) begin
         px_ff <= PCW'(x_ff[NS]) * gain;
         py_ff <= PCW'(y_ff[NS]) * gain;
         sb_ff[NS+1] <= sb_ff[NS];
      end
   end

   assign xr = px_ff + (PCW'(1) <<< (mwm_pkg::GAIN_SHIFT - 1));
   assign yr = py_ff + (PCW'(1) <<< (mwm_pkg::GAIN_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (rdy[NS+2]) begin
         rx_ff <= xr[mwm_pkg::GAIN_SHIFT + mwm_pkg::RW - 1:mwm_pkg::GAIN_SHIFT];
         ry_ff <= yr[mwm_pkg::GAIN_SHIFT + mwm_pkg::RW - 1:mwm_pkg::GAIN_SHIFT];
         sb_ff[NS+2] <= sb_ff[NS+1];
      end
   end

   assign out_x = rx_ff;
   assign out_y = ry_ff;
   assign out_side = sb_ff[NST-1];

   assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> (z_ff[0] <= ZW'(mwm_pkg::QUARTER_TURN))
               && (z_ff[0] >= -ZW'(mwm_pkg::QUARTER_TURN)))
      else $error("cordic angle not folded");

   assert property (@(posedge clock) disable iff (reset)
      (v_ff[NST-1] && !out_ready) |=> v_ff[NST-1])
      else $error("cordic result lost under stall");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> v_ff[0])
      else $error("cordic transfer not captured");

endmodule

`default_nettype wire

[design/mwm_norm.sv]
// Pipelined restoring dividers: speed normalization and measured-rate scaling.
`default_nettype none

module mwm_norm (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire mwm_pkg::peak_type          in_pk,
   input  wire logic [14:0]                ms,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output mwm_pkg::quot_type               out_q
);

   localparam int DW = mwm_pkg::MW;
   localparam int QW = mwm_pkg::QW;
   localparam int PER = mwm_pkg::DIV_PER_STAGE;
   localparam int NDS = mwm_pkg::DIV_STEPS / PER;
   localparam int LN = mwm_pkg::DIV_LANES;
   localparam int WH = mwm_pkg::WHEELS;

   logic [NDS-1:0] v_ff;
   logic [NDS:0] rdy;
   logic [DW-1:0] rem_ff [0:NDS-1][0:LN-1];
   logic [QW-1:0] q_ff [0:NDS-1][0:LN-1];
   mwm_pkg::peak_type pk_ff [0:NDS-1];

   always_comb begin
      rdy[NDS] = out_ready;
      for (int k = NDS - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready = rdy[0];
   assign out_valid = v_ff[NDS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NDS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   genvar k;
   generate
      for (k = 0; k < NDS; k++) begin : g_st
         mwm_pkg::peak_type pk_src;
         logic [DW-1:0] rem_src [0:LN-1];
         logic [QW-1:0] q_src [0:LN-1];
         logic [DW-1:0] den [0:LN-1];
         logic [DW-1:0] rem_nx [0:LN-1];
         logic [QW-1:0] q_nx [0:LN-1];

         if (k == 0) begin : g_src
            // lanes 0..3 divide by the peak, lanes 4..7 by max_speed
            always_comb begin
               pk_src = in_pk;
               for (int l = 0; l < WH; l++) begin
                  rem_src[l] = in_pk.mag[l];
                  rem_src[l+WH] = DW'(in_pk.rmag[l]);
                  q_src[l] = '0;
                  q_src[l+WH] = '0;
               end
            end
         end else begin : g_src
            always_comb begin
               pk_src = pk_ff[k-1];
               for (int l = 0; l < LN; l++) begin
                  rem_src[l] = rem_ff[k-1][l];
                  q_src[l] = q_ff[k-1][l];
               end
            end
         end

         always_comb begin
            for (int l = 0; l < WH; l++) begin
               den[l] = pk_src.peak;
               den[l+WH] = DW'(ms);
            end
         end

         always_comb begin
            logic [DW:0] t;
            logic [DW-1:0] r;
            logic [QW-1:0] q;
            for (int l = 0; l < LN; l++) begin
               r = rem_src[l];
               q = q_src[l];
               for (int j = 0; j < PER; j++) begin
                  t = {r, 1'b0};
                  if (t >= {1'b0, den[l]}) begin
                     t = t - {1'b0, den[l]};
                     q = {q[QW-2:0], 1'b1};
                  end else begin
                     q = {q[QW-2:0], 1'b0};
                  end
                  r = t[DW-1:0];
               end
               rem_nx[l] = r;
               q_nx[l] = q;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               pk_ff[k] <= pk_src;
               for (int l = 0; l < LN; l++) begin
                  rem_ff[k][l] <= rem_nx[l];
                  q_ff[k][l] <= q_nx[l];
               end
            end
         end
      end
   endgenerate

   always_comb begin
      out_q.pk = pk_ff[NDS-1];
      for (int l = 0; l < WH; l++) begin
         out_q.q_s[l] = q_ff[NDS-1][l];
         out_q.q_r[l] = q_ff[NDS-1][l+WH];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (v_ff[NDS-1] && !out_ready) |=> v_ff[NDS-1])
      else $error("divider result lost under stall");

   assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> (rem_ff[0][0] < pk_ff[0].peak) || !pk_ff[0].do_norm
               || (pk_ff[0].mag[0] == pk_ff[0].peak))
      else $error("normalize remainder out of range");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> v_ff[0])
      else $error("divider transfer not captured");

endmodule

`default_nettype wire

[design/mwm_limit.sv]
// Pegged-wheel limit, clamp, max_speed scaling and the result register.
`default_nettype none

module mwm_limit (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          in_valid,
   output logic                                               in_ready,
   input  wire mwm_pkg::quot_type                             in_q,
   input  wire logic [14:0]                                   ms,
   output logic                                               out_valid,
   input  wire logic                                          out_ready,
   output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::IN_W-1:0]      setpoint
);

   localparam int NST = 4;
   localparam int WH = mwm_pkg::WHEELS;
   localparam int MAGW = mwm_pkg::MAGW;
   localparam int PW = 31;

   logic [NST-1:0] v_ff;
   logic [NST:0] rdy;

   logic [MAGW-1:0] smag_ff [0:WH-1];
   logic [WH-1:0] sgn0_ff, sgn1_ff, sgn2_ff;
   logic [MAGW-1:0] limit_ff;
   logic [WH-1:0] sel_ff;
   logic [MAGW-1:0] cm_ff [0:WH-1];
   logic [PW-1:0] p_ff [0:WH-1];
   logic [mwm_pkg::IN_W-1:0] set_ff [0:WH-1];

   logic [MAGW-1:0] smag_in [0:WH-1];
   logic [MAGW-1:0] limit_in;
   logic [WH-1:0] sel_in;
   logic [MAGW-1:0] cm_in [0:WH-1];
   logic [mwm_pkg::IN_W-1:0] set_in [0:WH-1];

   always_comb begin
      rdy[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready = rdy[0];
   assign out_valid = v_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // final normalized magnitude; pick the slowest pegged wheel, first one wins ties
   always_comb begin
      for (int l = 0; l < WH; l++) begin
         if (!in_q.pk.do_norm) begin
            smag_in[l] = in_q.pk.mag[l][MAGW-1:0];
         end else if (in_q.pk.mag[l] == in_q.pk.peak) begin
            smag_in[l] = MAGW'(mwm_pkg::ONE_Q15);
         end else begin
            smag_in[l] = {1'b0, in_q.q_s[l]};
         end
      end
      limit_in = MAGW'(mwm_pkg::ONE_Q15);
      sel_in = '0;
      for (int l = 0; l < WH; l++) begin
         if (in_q.pk.lim_ok[l] && ({1'b0, in_q.q_r[l]} < limit_in)) begin
            limit_in = {1'b0, in_q.q_r[l]};
            sel_in = WH'(1) << l;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int l = 0; l < WH; l++) begin
            smag_ff[l] <= smag_in[l];
         end
         sgn0_ff <= in_q.pk.sgn;
         limit_ff <= limit_in;
         sel_ff <= sel_in;
      end
   end

   always_comb begin
      for (int l = 0; l < WH; l++) begin
         if ((|sel_ff) && !sel_ff[l] && (smag_ff[l] > limit_ff)) begin
            cm_in[l] = limit_ff;
         end else begin
            cm_in[l] = smag_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         for (int l = 0; l < WH; l++) begin
            cm_ff[l] <= cm_in[l];
         end
         sgn1_ff <= sgn0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         for (int l = 0; l < WH; l++) begin
            p_ff[l] <= PW'(cm_ff[l]) * PW'(ms);
         end
         sgn2_ff <= sgn1_ff;
      end
   end

   // round half away from zero on the magnitude, saturate, restore sign
   always_comb begin
      logic [PW-1:0] t;
      logic [MAGW-1:0] q;
      for (int l = 0; l < WH; l++) begin
         t = p_ff[l] + PW'(mwm_pkg::ONE_Q15 / 2);
         q = t[mwm_pkg::FRAC + MAGW - 1:mwm_pkg::FRAC];
         if (q > 16'd32767) begin
            q = 16'd32767;
         end
         set_in[l] = sgn2_ff[l] ? (~q + 16'd1) : q;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int l = 0; l < WH; l++) begin
            set_ff[l] <= set_in[l];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < WH; l++) begin
         setpoint[l] = set_ff[l];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> $onehot0(sel_ff))
      else $error("more than one limiting wheel");

   assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> (limit_ff <= MAGW'(mwm_pkg::ONE_Q15)))
      else $error("limit above full scale");

   assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && rdy[1] && (|sel_ff) && !sel_ff[0]) |=> (cm_ff[0] <= $past(limit_ff)))
      else $error("front-left not clamped to limit");

endmodule

`default_nettype wire

[bench/mecanum_wheel_mixer_equalizer_tb.sv]
// Self-checking testbench for the mecanum wheel mixer with pegged-wheel equalization.
`timescale 1ns / 100ps

module mecanum_wheel_mixer_equalizer_tb;

   localparam int RANDOM_ITEMS = 1000;
   localparam int IDLE_LIMIT = 2000;   // cycles with no transfer before giving up
   localparam int DRAIN_CYCLES = 40;   // pipeline is 22 deep

   typedef struct {
      logic signed [15:0] x, y, rot;
      logic [15:0] hdg;
      logic signed [15:0] drv [4];
      logic signed [15:0] rt [4];
   } command_type;

   typedef struct {
      logic signed [15:0] sp [4];
   } setpoints_type;

   // directed row: command plus optional typed-in answer
   typedef struct {
      command_type cmd;
      bit has_answer;
      setpoints_type answer;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_cmd_x = '0, req_cmd_y = '0, req_cmd_rotate = '0;
   logic [15:0] req_heading = '0;
   logic signed [15:0] req_drive_fl = '0, req_drive_fr = '0, req_drive_rl = '0, req_drive_rr = '0;
   logic signed [15:0] req_rate_fl = '0, req_rate_fr = '0, req_rate_rl = '0, req_rate_rr = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_setpoint_fl, rsp_setpoint_fr, rsp_setpoint_rl, rsp_setpoint_rr;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mwm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mwm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   mecanum_wheel_mixer_equalizer dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // shadow copy of the control registers
   logic [14:0] full_scale = mwm_pkg::MAX_SPEED_RESET;
   logic [3:0] wheel_flip = mwm_pkg::INVERT_MASK_RESET;
   logic [14:0] peg_level = mwm_pkg::PEG_THRESHOLD_RESET;

   setpoints_type pending_setpoints [$];
   bit failed = 1'b0;
   int idle_cycles = 0;

   // ------------------------------------------------------------------
   // predictor helpers
   // ------------------------------------------------------------------
   // arithmetic shift right, floor semantics
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint absval(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint arctan_step(int i);
      longint tab [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                           41, 20, 10, 5, 3, 1, 1, 0};
      return tab[i];
   endfunction

   // rotate the command vector by the heading, Q1.15 in and out
   function automatic void rotate_command(inout longint vx, inout longint vy,
                                          input logic [15:0] hdg);
      longint ax, ay, az, nx;
      ax = vx * 256;
      ay = vy * 256;
      az = longint'($signed(hdg));
      // fold into +-90 degrees with an exact half turn
      if (az > mwm_pkg::QUARTER_TURN) begin
         ax = -ax; ay = -ay; az -= mwm_pkg::HALF_TURN;
      end else if (az < -mwm_pkg::QUARTER_TURN) begin
         ax = -ax; ay = -ay; az += mwm_pkg::HALF_TURN;
      end
      for (int i = 0; i < 16; i++) begin
         if (az >= 0) begin
            nx = ax - shr_floor(ay, i);
            ay = ay + shr_floor(ax, i);
            az -= arctan_step(i);
         end else begin
            nx = ax + shr_floor(ay, i);
            ay = ay - shr_floor(ax, i);
            az += arctan_step(i);
         end
         ax = nx;
      end
      // gain correction, round half up
      vx = shr_floor(ax * mwm_pkg::GAIN_INV + (longint'(1) << 23), 24);
      vy = shr_floor(ay * mwm_pkg::GAIN_INV + (longint'(1) << 23), 24);
   endfunction

   // full mix / normalize / equalize / scale
   function automatic setpoints_type mix_wheels(command_type c);
      setpoints_type res;
      longint vx, vy, vr, s [4], peak, lim, ms, nr, q;
      int limiter;
      vx = c.x; vy = c.y; vr = c.rot;
      lim = mwm_pkg::ONE_Q15;
      limiter = -1;
      ms = (full_scale == 0) ? 1 : full_scale;
      rotate_command(vx, vy, c.hdg);
      s[0] = vx + vy + vr;
      s[1] = -vx + vy - vr;
      s[2] = -vx + vy + vr;
      s[3] = vx + vy - vr;
      peak = 0;
      for (int i = 0; i < 4; i++) begin
         if (wheel_flip[i]) s[i] = -s[i];
         if (absval(s[i]) > peak) peak = absval(s[i]);
      end
      if (peak > mwm_pkg::ONE_Q15) begin
         for (int i = 0; i < 4; i++) begin
            q = (absval(s[i]) * mwm_pkg::ONE_Q15) / peak;
            s[i] = s[i] < 0 ? -q : q;
         end
      end
      // slowest pegged wheel sets the ceiling for the others
      for (int i = 0; i < 4; i++) begin
         if (absval(c.drv[i]) > peg_level) begin
            nr = (absval(c.rt[i]) * mwm_pkg::ONE_Q15) / ms;
            if (nr < lim) begin
               lim = nr; limiter = i;
            end
         end
      end
      if (limiter >= 0) begin
         for (int i = 0; i < 4; i++) begin
            if (i != limiter) begin
               if (s[i] > lim) s[i] = lim;
               else if (s[i] < -lim) s[i] = -lim;
            end
         end
      end
      for (int i = 0; i < 4; i++) begin
         q = (absval(s[i]) * ms + mwm_pkg::ONE_Q15 / 2) / mwm_pkg::ONE_Q15;
         if (q > 32767) q = 32767;
         res.sp[i] = 16'(s[i] < 0 ? -q : q);
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // command side
   // ------------------------------------------------------------------
   task automatic send_command(command_type c, bit has_answer, setpoints_type answer);
      int gap;
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd_x <= c.x; req_cmd_y <= c.y; req_cmd_rotate <= c.rot; req_heading <= c.hdg;
      req_drive_fl <= c.drv[0]; req_drive_fr <= c.drv[1];
      req_drive_rl <= c.drv[2]; req_drive_rr <= c.drv[3];
      req_rate_fl <= c.rt[0]; req_rate_fr <= c.rt[1];
      req_rate_rl <= c.rt[2]; req_rate_rr <= c.rt[3];
      // expectation queued at the transfer edge
      do @(posedge clock); while (req_stall);
      pending_setpoints = {pending_setpoints, (has_answer ? answer : mix_wheels(c))};
   endtask

   task automatic write_register(logic [mwm_pkg::CSR_IDX_W-1:0] idx, logic [14:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mwm_pkg::REG_MAX_SPEED:     full_scale = val;
         mwm_pkg::REG_INVERT_MASK:   wheel_flip = val[3:0];
         mwm_pkg::REG_PEG_THRESHOLD: peg_level = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // block is idle once every result is back and the pipe has flushed
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic command_type random_command(bit peg_heavy);
      command_type c;
      c.x = 16'($urandom); c.y = 16'($urandom); c.rot = 16'($urandom);
      c.hdg = 16'($urandom);
      // scaled-down commands keep normalization off, full-range ones often need it
      if ($urandom_range(0, 2) == 0) begin
         c.x = $signed(c.x) >>> 2; c.y = $signed(c.y) >>> 2; c.rot = $signed(c.rot) >>> 2;
      end
      for (int i = 0; i < 4; i++) begin
         c.drv[i] = 16'($urandom);
         // push drive near full scale so wheels peg often
         if (peg_heavy && $urandom_range(0, 1)) begin
            c.drv[i] = $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 600))
                                             : -16'sh7FFF + 16'($urandom_range(0, 600));
         end
         c.rt[i] = $urandom_range(0, 1) ? 16'($urandom)
                                        : 16'($signed(16'($urandom_range(0, 2000))) -
                                              16'sd1000);
      end
      // occasional tie among measured rates
      if ($urandom_range(0, 7) == 0) c.rt[1] = c.rt[0];
      return c;
   endfunction

   function automatic command_type make_cmd(logic [15:0] x, y, r, h, d, rt);
      command_type c;
      c.x = x; c.y = y; c.rot = r; c.hdg = h;
      for (int i = 0; i < 4; i++) begin
         c.drv[i] = d; c.rt[i] = rt;
      end
      return c;
   endfunction

   // ------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------
   row_type directed [$];

   function automatic setpoints_type all_four(logic signed [15:0] a, b, c, d);
      setpoints_type s;
      s.sp[0] = a; s.sp[1] = b; s.sp[2] = c; s.sp[3] = d;
      return s;
   endfunction

   task automatic build_table();
      row_type r;
      setpoints_type none;
      none = all_four(0, 0, 0, 0);
      // all zero gives zero setpoints
      r.cmd = make_cmd(0, 0, 0, 0, 0, 0); r.has_answer = 1; r.answer = none;
      directed = {directed, r};
      // pure rotate at half scale: +-500 with max_speed 1000
      r.cmd = make_cmd(0, 0, 16'sd16384, 0, 0, 0); r.has_answer = 1;
      r.answer = all_four(500, -500, 500, -500);
      directed = {directed, r};
      // full negative rotate: peak exactly one, no normalization
      r.cmd = make_cmd(0, 0, 16'sh8000, 0, 0, 0); r.has_answer = 1;
      r.answer = all_four(-1000, 1000, -1000, 1000);
      directed = {directed, r};
      r.has_answer = 0;
      // extremes of every command field and heading quadrants
      r.cmd = make_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0); directed = {directed, r};
      r.cmd = make_cmd(16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 0, 0);
      directed = {directed, r};
      r.cmd = make_cmd(16'sh7FFF, 16'sh8000, 0, 16'h4000, 0, 0); directed = {directed, r};
      r.cmd = make_cmd(16'sh4000, 16'sh2000, 0, 16'h4001, 0, 0); directed = {directed, r};
      r.cmd = make_cmd(16'sh4000, 16'sh2000, 0, 16'hBFFF, 0, 0); directed = {directed, r};
      r.cmd = make_cmd(16'sh4000, 16'sh2000, 0, 16'h8000, 0, 0); directed = {directed, r};
      r.cmd = make_cmd(16'sh1234, 16'sh5678, 16'sh0F0F, 16'hC000, 0, 0);
      directed = {directed, r};
      // all pegged with identical rates: tie, fl limits the rest
      r.cmd = make_cmd(16'sh4000, 16'sh4000, 16'sh1000, 0, 16'sh7FFF, 16'sd300);
      directed = {directed, r};
      // pegged negative drive with most negative rate
      r.cmd = make_cmd(16'sh2000, 16'sh6000, 16'sh8000, 16'h2000, 16'sh8000, 16'sh8000);
      directed = {directed, r};
      // pegged but rate at full scale: no limiting wheel
      r.cmd = make_cmd(16'sh2000, 16'sh6000, 16'sh1000, 0, 16'sh7FFF, 16'sd1000);
      directed = {directed, r};
      // drive exactly at threshold is not pegged
      r.cmd = make_cmd(16'sh2000, 16'sh6000, 16'sh1000, 0, 16'sd32440, 16'sd0);
      directed = {directed, r};
      r.cmd = make_cmd(16'sh2000, 16'sh6000, 16'sh1000, 0, 16'sd32441, 16'sd0);
      directed = {directed, r};
      // single pegged wheel, the others clamped to its rate
      r.cmd = make_cmd(16'sh3000, 16'sh3000, 16'sh0800, 16'h1000, 0, 16'sh7FFF);
      r.cmd.drv[2] = 16'sh8001; r.cmd.rt[2] = -16'sd250;
      directed = {directed, r};
   endtask

   // ------------------------------------------------------------------
   // result side: random stall and checking
   // ------------------------------------------------------------------
   // per result: stall at random, then take it
   initial begin
      int hold;
      forever begin
         hold = $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      setpoints_type want;
      logic signed [15:0] got [4];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_setpoint_fl, rsp_setpoint_fr, rsp_setpoint_rl, rsp_setpoint_rr};
         if (pending_setpoints.size() == 0) begin
            $display("%0t: unexpected setpoint transfer, expected none, actual %0d %0d %0d %0d",
                     $time, got[0], got[1], got[2], got[3]);
            failed = 1'b1;
         end else begin
            want = pending_setpoints.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (got[i] !== want.sp[i]) begin
                  $display("%0t: setpoint of wheel %0d, expected %0d, actual %0d",
                           $time, i, want.sp[i], got[i]);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transfer while work is outstanding
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset ||
          (pending_setpoints.size() == 0 && !req_valid))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[mecanum_wheel_mixer_equalizer] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      setpoints_type unused;
      logic [14:0] speeds [6] = '{15'd1000, 15'd1, 15'd32767, 15'd0, 15'd4095, 15'd20000};
      logic [14:0] pegs [6] = '{15'd32440, 15'd0, 15'd32767, 15'd16384, 15'd30000, 15'd0};
      build_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under reset register values
      foreach (directed[i]) send_command(directed[i].cmd, directed[i].has_answer,
                                         directed[i].answer);
      wait_idle();
      // index beyond the list must be ignored
      write_register(2'd3, 15'h7FFF);
      send_command(make_cmd(0, 0, 16'sd16384, 0, 0, 0), 1, all_four(500, -500, 500, -500));
      wait_idle();

      // random phases across register settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         write_register(mwm_pkg::REG_MAX_SPEED, speeds[ph]);
         write_register(mwm_pkg::REG_INVERT_MASK,
                        ph == 2 ? 15'hF : 15'($urandom_range(0, 15)));
         write_register(mwm_pkg::REG_PEG_THRESHOLD, pegs[ph]);
         for (int n = 0; n < RANDOM_ITEMS / 6; n++)
            send_command(random_command($urandom_range(0, 3) != 0), 0, unused);
         wait_idle();
      end

      if (!failed && pending_setpoints.size() == 0)
         $display("[mecanum_wheel_mixer_equalizer] OK");
      else
         $display("[mecanum_wheel_mixer_equalizer] ERROR");
      $finish;
   end

endmodule

[sim.f]
design/mwm_pkg.sv
design/mwm_cordic.sv
design/mwm_norm.sv
design/mwm_limit.sv
design/mecanum_wheel_mixer_equalizer.sv
bench/mecanum_wheel_mixer_equalizer_tb.sv
